### rtl/ustb_pkg.sv
// Package: types, codes and CRC helper for the UART to SPI flash command bridge.
`default_nettype none
package ustb_pkg;

    localparam int PAGE_BYTES = 256;
    localparam logic [8:0] PAGE_CNT = 9'(PAGE_BYTES);

    localparam logic [1:0] K_UART = 2'd0;
    localparam logic [1:0] K_SPI  = 2'd1;
    localparam logic [1:0] K_TICK = 2'd2;

    localparam logic [1:0] T_SPI  = 2'd0;
    localparam logic [1:0] T_UART = 2'd1;
    localparam logic [1:0] T_CS   = 2'd2;
    localparam logic [1:0] T_PWM  = 2'd3;

    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_RDID  = 8'h9f;
    localparam logic [7:0] C_ERASE = 8'hc7;
    localparam logic [7:0] C_WREN  = 8'h06;
    localparam logic [7:0] C_RDSR  = 8'h05;
    localparam logic [7:0] C_PP    = 8'h02;
    localparam logic [7:0] C_READ  = 8'h03;
    localparam logic [7:0] C_DUMMY = 8'h55;
    localparam logic [7:0] C_MID   = 8'h80;
    localparam logic [7:0] C_DONE  = 8'h01;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [2:0] CMD_ID    = 3'd0;
    localparam logic [2:0] CMD_ERASE = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_PLAY  = 3'd4;
    localparam logic [2:0] CMD_CRC   = 3'd5;
    localparam logic [2:0] CMD_FILL  = 3'd6;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0, PH_CMD = 5'd1, PH_WREN = 5'd2, PH_ERASE = 5'd3,
        PH_STAT_CMD = 5'd4, PH_STAT_VAL = 5'd5, PH_OPC = 5'd6, PH_ADDR_IN = 5'd7,
        PH_ADDR_ECHO = 5'd8, PH_LEN_IN = 5'd9, PH_DATA_IN = 5'd10, PH_READ = 5'd11,
        PH_DATA_ECHO = 5'd12, PH_FILL_IN = 5'd13, PH_FILL = 5'd14, PH_ID = 5'd15,
        PH_ID_DATA = 5'd16, PH_WORD_IN = 5'd17, PH_CRC = 5'd18, PH_ADDR_OUT = 5'd19
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_in;

    typedef struct packed {
        logic [1:0] target;
        logic [7:0] value;
        logic       last;
    } t_out;

    // Up to four results from one request
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][1:0] target;
        logic [3:0][7:0] value;
    } t_res;

    // One CRC-16/XMODEM byte step
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/ustb_core.sv
// Command state machine: one request in, a group of up to four results out.
`default_nettype none
module ustb_core
    import ustb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_in  i_req,
    output t_res      o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cmd, n_cmd;
    logic [8:0]  r_cnt, n_cnt;
    logic [23:0] r_word, n_word;
    logic [23:0] r_crclen, n_crclen;
    logic [23:0] r_play, n_play;
    logic        r_playing, n_playing;
    logic [15:0] r_crc, n_crc;
    logic        r_pend, n_pend;
    logic [7:0]  r_fill, n_fill;

    // Append one result to a group
    function automatic t_res add_res(input t_res r, input logic [1:0] t, input logic [7:0] v);
        t_res a;
        a = r;
        a.target[r.count[1:0]] = t;
        a.value[r.count[1:0]]  = v;
        a.count = r.count + 3'd1;
        return a;
    endfunction

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_cmd <= '0; r_cnt <= '0; r_word <= '0;
            r_crclen <= '0; r_play <= '0; r_playing <= 1'b0; r_crc <= '0;
            r_pend <= 1'b0; r_fill <= '0;
        end else if (i_en) begin
            r_phase <= n_phase; r_cmd <= n_cmd; r_cnt <= n_cnt; r_word <= n_word;
            r_crclen <= n_crclen; r_play <= n_play; r_playing <= n_playing;
            r_crc <= n_crc; r_pend <= n_pend; r_fill <= n_fill;
        end
    end

    // Next state and results
    always_comb begin
        logic [7:0]  d;
        logic [15:0] crc_new;
        logic [8:0]  cnt_dec;
        logic [2:0]  code;
        t_phase      ph;
        d = i_req.data;
        crc_new = crc_step(r_crc, d);
        cnt_dec = r_cnt - 9'd1;
        code = 3'(d - 8'h30);
        ph = r_phase;
        if (r_phase > PH_ADDR_OUT) ph = PH_IDLE;
        n_phase = r_phase; n_cmd = r_cmd; n_cnt = r_cnt; n_word = r_word;
        n_crclen = r_crclen; n_play = r_play; n_playing = r_playing; n_crc = r_crc;
        n_pend = r_pend; n_fill = r_fill;
        o_res = '0;

        if (r_pend) begin
            if (i_req.kind == K_SPI) begin
                n_pend = 1'b0;
                case (ph)
                    PH_WREN: begin
                        o_res = add_res(o_res, T_CS, 8'd1);
                        o_res = add_res(o_res, T_CS, 8'd0);
                        n_pend = 1'b1;
                        if (r_cmd == CMD_ERASE) begin
                            o_res = add_res(o_res, T_SPI, C_ERASE); n_phase = PH_ERASE;
                        end else begin
                            o_res = add_res(o_res, T_SPI, C_PP); n_phase = PH_OPC;
                        end
                    end
                    PH_ERASE: begin
                        o_res = add_res(o_res, T_CS, 8'd1);
                        o_res = add_res(o_res, T_CS, 8'd0);
                        o_res = add_res(o_res, T_SPI, C_RDSR);
                        n_pend = 1'b1; n_phase = PH_STAT_CMD;
                    end
                    PH_STAT_CMD: begin
                        o_res = add_res(o_res, T_SPI, C_DUMMY);
                        n_pend = 1'b1; n_phase = PH_STAT_VAL;
                    end
                    PH_STAT_VAL: begin
                        o_res = add_res(o_res, T_CS, 8'd1);
                        if (d[0]) begin
                            o_res = add_res(o_res, T_CS, 8'd0);
                            o_res = add_res(o_res, T_SPI, C_RDSR);
                            n_pend = 1'b1; n_phase = PH_STAT_CMD;
                        end else begin
                            o_res = add_res(o_res, T_UART, C_DONE); n_phase = PH_IDLE;
                        end
                    end
                    PH_OPC: begin
                        n_cnt = '0;
                        if (r_cmd == CMD_PLAY || r_cmd == CMD_CRC) begin
                            o_res = add_res(o_res, T_SPI, r_word[23:16]); n_pend = 1'b1;
                            n_phase = PH_ADDR_OUT;
                        end else n_phase = PH_ADDR_IN;
                    end
                    PH_ADDR_OUT: begin
                        n_cnt = r_cnt + 9'd1;
                        if (n_cnt == 9'd1) begin
                            o_res = add_res(o_res, T_SPI, r_word[15:8]); n_pend = 1'b1;
                        end else if (n_cnt == 9'd2) begin
                            o_res = add_res(o_res, T_SPI, r_word[7:0]); n_pend = 1'b1;
                        end else if (r_cmd == CMD_PLAY) begin
                            n_playing = 1'b1; n_phase = PH_IDLE;
                        end else if (r_crclen == '0) begin
                            o_res = add_res(o_res, T_CS, 8'd1);
                            o_res = add_res(o_res, T_UART, r_crc[15:8]);
                            o_res = add_res(o_res, T_UART, r_crc[7:0]);
                            n_phase = PH_IDLE;
                        end else begin
                            o_res = add_res(o_res, T_SPI, 8'h00);
                            n_pend = 1'b1; n_phase = PH_CRC;
                        end
                    end
                    PH_ADDR_ECHO: begin
                        if (r_cnt < 9'd3) n_phase = PH_ADDR_IN;
                        else n_phase = (r_cmd == CMD_FILL) ? PH_FILL_IN : PH_LEN_IN;
                    end
                    PH_DATA_ECHO: begin
                        n_cnt = cnt_dec;
                        if (cnt_dec != '0) n_phase = PH_DATA_IN;
                        else begin
                            o_res = add_res(o_res, T_CS, 8'd1);
                            o_res = add_res(o_res, T_CS, 8'd0);
                            o_res = add_res(o_res, T_SPI, C_RDSR);
                            n_pend = 1'b1; n_phase = PH_STAT_CMD;
                        end
                    end
                    PH_READ: begin
                        o_res = add_res(o_res, T_UART, d);
                        n_cnt = cnt_dec;
                        if (cnt_dec != '0) begin
                            o_res = add_res(o_res, T_SPI, C_DUMMY); n_pend = 1'b1;
                        end else begin
                            o_res = add_res(o_res, T_CS, 8'd1); n_phase = PH_IDLE;
                        end
                    end
                    PH_FILL: begin
                        n_cnt = cnt_dec;
                        if (cnt_dec != '0) begin
                            o_res = add_res(o_res, T_SPI, r_fill); n_pend = 1'b1;
                        end else begin
                            o_res = add_res(o_res, T_CS, 8'd1);
                            o_res = add_res(o_res, T_CS, 8'd0);
                            o_res = add_res(o_res, T_SPI, C_RDSR);
                            n_pend = 1'b1; n_phase = PH_STAT_CMD;
                        end
                    end
                    PH_ID: begin
                        n_cnt = '0; o_res = add_res(o_res, T_SPI, 8'h00); n_pend = 1'b1;
                        n_phase = PH_ID_DATA;
                    end
                    PH_ID_DATA: begin
                        o_res = add_res(o_res, T_UART, d);
                        n_cnt = r_cnt + 9'd1;
                        if (n_cnt < 9'd3) begin
                            o_res = add_res(o_res, T_SPI, 8'h00); n_pend = 1'b1;
                        end else begin
                            o_res = add_res(o_res, T_CS, 8'd1); n_phase = PH_IDLE;
                        end
                    end
                    PH_CRC: begin
                        n_crc = crc_new;
                        n_crclen = r_crclen - 24'd1;
                        if (n_crclen != '0) begin
                            o_res = add_res(o_res, T_SPI, 8'h00); n_pend = 1'b1;
                        end else begin
                            o_res = add_res(o_res, T_CS, 8'd1);
                            o_res = add_res(o_res, T_UART, crc_new[15:8]);
                            o_res = add_res(o_res, T_UART, crc_new[7:0]);
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        // idle: the reply is a playback sample
                        n_phase = PH_IDLE;
                        o_res = add_res(o_res, T_PWM, d);
                        n_play = r_play - 24'd1;
                    end
                endcase
            end
        end else if (i_req.kind == K_UART) begin
            case (ph)
                PH_CMD: begin
                    if (d < 8'h30 || d > 8'h36) n_phase = PH_IDLE;
                    else begin
                        n_cmd = code; n_cnt = '0;
                        case (code)
                            CMD_ID: begin
                                o_res = add_res(o_res, T_CS, 8'd0);
                                o_res = add_res(o_res, T_SPI, C_RDID);
                                n_pend = 1'b1; n_phase = PH_ID;
                            end
                            CMD_ERASE, CMD_WRITE, CMD_FILL: begin
                                o_res = add_res(o_res, T_CS, 8'd0);
                                o_res = add_res(o_res, T_SPI, C_WREN);
                                n_pend = 1'b1; n_phase = PH_WREN;
                            end
                            CMD_READ: begin
                                o_res = add_res(o_res, T_CS, 8'd0);
                                o_res = add_res(o_res, T_SPI, C_READ);
                                n_pend = 1'b1; n_phase = PH_OPC;
                            end
                            CMD_PLAY: begin
                                n_word = '0; n_play = '0; n_phase = PH_WORD_IN;
                            end
                            default: begin
                                n_crclen = '0; n_phase = PH_WORD_IN;
                            end
                        endcase
                    end
                end
                PH_ADDR_IN: begin
                    n_cnt = r_cnt + 9'd1; o_res = add_res(o_res, T_SPI, d); n_pend = 1'b1;
                    n_phase = PH_ADDR_ECHO;
                end
                PH_LEN_IN: begin
                    n_cnt = (d != 8'd0) ? {1'b0, d} : PAGE_CNT;
                    if (r_cmd == CMD_READ) begin
                        o_res = add_res(o_res, T_SPI, C_DUMMY);
                        n_pend = 1'b1; n_phase = PH_READ;
                    end else n_phase = PH_DATA_IN;
                end
                PH_DATA_IN: begin
                    o_res = add_res(o_res, T_SPI, d); n_pend = 1'b1; n_phase = PH_DATA_ECHO;
                end
                PH_FILL_IN: begin
                    n_fill = d; n_cnt = PAGE_CNT; o_res = add_res(o_res, T_SPI, d);
                    n_pend = 1'b1; n_phase = PH_FILL;
                end
                PH_WORD_IN: begin
                    n_cnt = r_cnt + 9'd1;
                    if (r_cmd == CMD_PLAY) begin
                        if (r_cnt < 9'd3) n_word = {r_word[15:0], d};
                        else n_play = {r_play[15:0], d};
                        if (n_cnt >= 9'd6) begin
                            o_res = add_res(o_res, T_CS, 8'd0);
                            o_res = add_res(o_res, T_SPI, C_READ);
                            n_pend = 1'b1; n_phase = PH_OPC;
                        end
                    end else begin
                        n_crclen = {r_crclen[15:0], d};
                        if (n_cnt >= 9'd3) begin
                            n_crc = '0; n_word = '0;
                            o_res = add_res(o_res, T_CS, 8'd0);
                            o_res = add_res(o_res, T_SPI, C_READ);
                            n_pend = 1'b1; n_phase = PH_OPC;
                        end
                    end
                end
                PH_IDLE: begin
                    // an unreachable phase code falls back to idle here
                    n_phase = PH_IDLE;
                    if (d == C_HASH) begin
                        n_play = '0; n_playing = 1'b0; o_res = add_res(o_res, T_CS, 8'd1);
                        n_phase = PH_CMD;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_req.kind == K_TICK && r_playing) begin
            if (r_play == '0) begin
                o_res = add_res(o_res, T_CS, 8'd1);
                o_res = add_res(o_res, T_PWM, C_MID);
                n_playing = 1'b0;
            end else begin
                o_res = add_res(o_res, T_SPI, 8'h00); n_pend = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ustb_outq.sv
// Result queue: holds result groups and hands them out one per cycle while the receiver does not stall.
`default_nettype none
module ustb_outq
    import ustb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_res i_res,
    output logic      o_room,
    output logic      o_valid,
    output t_out      o_data,
    input  wire logic i_stall
);

    // Eight-entry result FIFO; a group enters only when four slots are free
    logic [7:0][9:0] r_q;
    logic [7:0]      r_last;
    logic [2:0]      r_rd, r_wr;
    logic [3:0]      r_cnt;
    logic [3:0]      n_cnt;
    logic            pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_cnt != 4'd0);
    assign o_room  = (r_cnt - 4'(pop)) <= 4'd4;
    assign o_data  = {r_q[r_rd], r_last[r_rd]};

    always_comb begin
        n_cnt = r_cnt - 4'(pop) + (i_wr ? {1'b0, i_res.count} : 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            if (pop) r_rd <= r_rd + 3'd1;
            if (i_wr) r_wr <= r_wr + i_res.count;
            r_cnt <= n_cnt;
        end
    end

    // Payload writes
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < i_res.count) begin
                    r_q[r_wr + 3'(k)]    <= {i_res.target[k], i_res.value[k]};
                    r_last[r_wr + 3'(k)] <= (3'(k + 1) == i_res.count);
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/uart_to_spi_flash_command_bridge.sv
// Top level of the UART to SPI flash command bridge.
// Input channel: i_in_valid / o_in_stall carry one request {kind, data}: a UART byte,
// an SPI reply byte or a sample tick.
// Output channel: o_out_valid / i_out_stall carry results {target, value, last}:
// SPI bytes, UART bytes, chip-select levels and PWM duty values; last marks the
// final result of one request.
// Each request is processed in the cycle it is accepted; its zero to four results
// are written to an eight-entry result queue and leave it one per cycle while the
// receiver does not stall. A request is accepted every cycle while the queue has four
// free slots, so throughput is one request per cycle as long as results average one
// per cycle. When the receiver stalls, the queue fills and o_in_stall rises.
// Synchronous reset returns to idle (waiting for '#') and empties the queue.
`default_nettype none
module uart_to_spi_flash_command_bridge
    import ustb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    t_res res;
    logic room, acc;

    assign o_in_stall = !room;
    assign acc = i_in_valid && room;

    ustb_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(acc), .i_req(i_in_data), .o_res(res)
    );

    ustb_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(acc), .i_res(res), .o_room(room),
        .o_valid(o_out_valid), .o_data(o_out_data), .i_stall(i_out_stall)
    );

endmodule
`default_nettype wire

### rtl/ustb_checker.sv
// Port-level checker for the bridge, bound to the top level.
`default_nettype none
module ustb_checker
    import ustb_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not empty after reset");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result without request");

endmodule

bind uart_to_spi_flash_command_bridge ustb_checker u_chk (.*);
`default_nettype wire

### verif/tb.sv
// Testbench for the UART to SPI flash command bridge: command stimulus, prediction and checking.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import ustb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    uart_to_spi_flash_command_bridge u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Bridge mirror state
    t_phase      br_phase;
    logic [2:0]  br_cmd;
    logic [8:0]  br_count;
    logic [23:0] br_addr;
    logic [23:0] br_crc_left;
    logic [23:0] br_play_left;
    logic        br_playing;
    logic [15:0] br_crc;
    logic        br_wait_reply;
    logic [7:0]  br_fill;

    t_in  request_queue[$];
    t_out expected_results[$];
    t_out step_out[$];
    int   error_count = 0;
    bit   stim_done = 0;
    int   hold_off = 0;
    int   quiet_from = 0;
    int   quiet_to = 0;
    int   cycle_count = 0;

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $time, what);
        error_count++;
    endtask

    function automatic void put(input logic [1:0] tgt, input logic [7:0] v);
        t_out r;
        r.target = tgt;
        r.value  = v;
        r.last   = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void spi_tx(input logic [7:0] b);
        put(T_SPI, b);
        br_wait_reply = 1'b1;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
        return x;
    endfunction

    function automatic void poll_status();
        put(T_CS, 8'd1);
        put(T_CS, 8'd0);
        spi_tx(C_RDSR);
        br_phase = PH_STAT_CMD;
    endfunction

    function automatic void crc_done();
        put(T_CS, 8'd1);
        put(T_UART, br_crc[15:8]);
        put(T_UART, br_crc[7:0]);
        br_phase = PH_IDLE;
    endfunction

    function automatic void bridge_uart(input logic [7:0] d);
        case (br_phase)
            PH_CMD: begin
                if (d < 8'h30 || d > 8'h36) begin
                    br_phase = PH_IDLE;
                end else begin
                    br_cmd = 3'(d - 8'h30);
                    br_count = '0;
                    case (br_cmd)
                        CMD_ID: begin
                            put(T_CS, 8'd0); spi_tx(C_RDID); br_phase = PH_ID;
                        end
                        CMD_ERASE, CMD_WRITE, CMD_FILL: begin
                            put(T_CS, 8'd0); spi_tx(C_WREN); br_phase = PH_WREN;
                        end
                        CMD_READ: begin
                            put(T_CS, 8'd0); spi_tx(C_READ); br_phase = PH_OPC;
                        end
                        CMD_PLAY: begin
                            br_addr = '0; br_play_left = '0; br_phase = PH_WORD_IN;
                        end
                        default: begin
                            br_crc_left = '0; br_phase = PH_WORD_IN;
                        end
                    endcase
                end
            end
            PH_ADDR_IN: begin
                br_count = br_count + 9'd1;
                spi_tx(d);
                br_phase = PH_ADDR_ECHO;
            end
            PH_LEN_IN: begin
                br_count = (d != 0) ? 9'(d) : PAGE_CNT;
                if (br_cmd == CMD_READ) begin
                    spi_tx(C_DUMMY); br_phase = PH_READ;
                end else begin
                    br_phase = PH_DATA_IN;
                end
            end
            PH_DATA_IN: begin
                spi_tx(d); br_phase = PH_DATA_ECHO;
            end
            PH_FILL_IN: begin
                br_fill = d; br_count = PAGE_CNT; spi_tx(d); br_phase = PH_FILL;
            end
            PH_WORD_IN: begin
                if (br_cmd == CMD_PLAY) begin
                    if (br_count < 3) br_addr = {br_addr[15:0], d};
                    else br_play_left = {br_play_left[15:0], d};
                    br_count = br_count + 9'd1;
                    if (br_count >= 6) begin
                        put(T_CS, 8'd0); spi_tx(C_READ); br_phase = PH_OPC;
                    end
                end else begin
                    br_crc_left = {br_crc_left[15:0], d};
                    br_count = br_count + 9'd1;
                    if (br_count >= 3) begin
                        br_crc = '0; br_addr = '0;
                        put(T_CS, 8'd0); spi_tx(C_READ); br_phase = PH_OPC;
                    end
                end
            end
            PH_IDLE: begin
                if (d == C_HASH) begin
                    br_play_left = '0; br_playing = 1'b0;
                    put(T_CS, 8'd1);
                    br_phase = PH_CMD;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void bridge_reply(input logic [7:0] d);
        case (br_phase)
            PH_WREN: begin
                put(T_CS, 8'd1); put(T_CS, 8'd0);
                if (br_cmd == CMD_ERASE) begin
                    spi_tx(C_ERASE); br_phase = PH_ERASE;
                end else begin
                    spi_tx(C_PP); br_phase = PH_OPC;
                end
            end
            PH_ERASE: poll_status();
            PH_STAT_CMD: begin
                spi_tx(C_DUMMY); br_phase = PH_STAT_VAL;
            end
            PH_STAT_VAL: begin
                put(T_CS, 8'd1);
                if (d[0]) begin
                    put(T_CS, 8'd0); spi_tx(C_RDSR); br_phase = PH_STAT_CMD;
                end else begin
                    put(T_UART, C_DONE); br_phase = PH_IDLE;
                end
            end
            PH_OPC: begin
                br_count = '0;
                if (br_cmd == CMD_PLAY || br_cmd == CMD_CRC) begin
                    spi_tx(br_addr[23:16]); br_phase = PH_ADDR_OUT;
                end else begin
                    br_phase = PH_ADDR_IN;
                end
            end
            PH_ADDR_OUT: begin
                br_count = br_count + 9'd1;
                if (br_count == 1) spi_tx(br_addr[15:8]);
                else if (br_count == 2) spi_tx(br_addr[7:0]);
                else if (br_cmd == CMD_PLAY) begin
                    br_playing = 1'b1; br_phase = PH_IDLE;
                end else if (br_crc_left == 0) crc_done();
                else begin
                    spi_tx(8'h00); br_phase = PH_CRC;
                end
            end
            PH_ADDR_ECHO: begin
                if (br_count < 3) br_phase = PH_ADDR_IN;
                else br_phase = (br_cmd == CMD_FILL) ? PH_FILL_IN : PH_LEN_IN;
            end
            PH_DATA_ECHO: begin
                br_count = br_count - 9'd1;
                if (br_count != 0) br_phase = PH_DATA_IN;
                else poll_status();
            end
            PH_READ: begin
                put(T_UART, d);
                br_count = br_count - 9'd1;
                if (br_count != 0) spi_tx(C_DUMMY);
                else begin
                    put(T_CS, 8'd1); br_phase = PH_IDLE;
                end
            end
            PH_FILL: begin
                br_count = br_count - 9'd1;
                if (br_count != 0) spi_tx(br_fill);
                else poll_status();
            end
            PH_ID: begin
                br_count = '0; spi_tx(8'h00); br_phase = PH_ID_DATA;
            end
            PH_ID_DATA: begin
                put(T_UART, d);
                br_count = br_count + 9'd1;
                if (br_count < 3) spi_tx(8'h00);
                else begin
                    put(T_CS, 8'd1); br_phase = PH_IDLE;
                end
            end
            PH_CRC: begin
                br_crc = crc_byte(br_crc, d);
                br_crc_left = br_crc_left - 24'd1;
                if (br_crc_left != 0) spi_tx(8'h00);
                else crc_done();
            end
            default: begin
                // playback sample
                br_phase = PH_IDLE;
                put(T_PWM, d);
                br_play_left = br_play_left - 24'd1;
            end
        endcase
    endfunction

    // Predict results of one accepted request
    function automatic void bridge_predict(input t_in rq);
        step_out.delete();
        if (br_wait_reply) begin
            if (rq.kind == K_SPI) begin
                br_wait_reply = 1'b0;
                bridge_reply(rq.data);
            end
        end else if (rq.kind == K_UART) begin
            bridge_uart(rq.data);
        end else if (rq.kind == K_TICK && br_playing) begin
            if (br_play_left == 0) begin
                put(T_CS, 8'd1); put(T_PWM, C_MID); br_playing = 1'b0;
            end else begin
                spi_tx(8'h00);
            end
        end
        if (step_out.size() > 4) step_out = step_out[0:3];
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endfunction

    // Stimulus helpers
    function automatic void send(input logic [1:0] k, input logic [7:0] d);
        t_in rq;
        rq.kind = k;
        rq.data = d;
        request_queue.push_back(rq);
    endfunction

    function automatic void uart_bytes(input int n);
        for (int i = 0; i < n; i++) send(K_UART, 8'($urandom));
    endfunction

    // Reply bytes with random content; bit 0 doubles as the busy flag
    function automatic void replies(input int n);
        for (int i = 0; i < n; i++) send(K_SPI, 8'($urandom));
    endfunction

    function automatic void cmd(input logic [7:0] c);
        send(K_UART, C_HASH);
        send(K_UART, c);
    endfunction

    // Well-formed command with random content, or a burst of noise; replies interleaved as needed
    function automatic void random_command();
        int  sel;
        int  n;
        sel = $urandom_range(0, 6);
        case (sel)
            0: begin cmd("0"); replies(4); end
            1: begin cmd("1"); replies(2); send(K_SPI, 8'h01); replies(2); send(K_SPI, 8'h00); end
            2: begin
                n = $urandom_range(1, 4);
                cmd("2"); replies(2);
                for (int i = 0; i < 3; i++) begin uart_bytes(1); replies(1); end
                send(K_UART, 8'(n));
                for (int i = 0; i < n; i++) begin uart_bytes(1); replies(1); end
                replies(1); send(K_SPI, 8'h00); replies(1);
            end
            3: begin
                n = $urandom_range(1, 5);
                cmd("3"); replies(1);
                for (int i = 0; i < 3; i++) begin uart_bytes(1); replies(1); end
                send(K_UART, 8'(n)); replies(n);
            end
            4: begin
                n = $urandom_range(0, 4);
                cmd("4"); uart_bytes(3);
                send(K_UART, 8'h00); send(K_UART, 8'h00); send(K_UART, 8'(n));
                replies(4);
                for (int i = 0; i <= n; i++) begin send(K_TICK, 8'($urandom)); replies(1); end
            end
            5: begin
                n = $urandom_range(0, 5);
                cmd("5"); send(K_UART, 8'h00); send(K_UART, 8'h00); send(K_UART, 8'(n));
                replies(4 + n);
            end
            default: begin
                // noise
                for (int i = 0; i < 4; i++) send(2'($urandom), 8'($urandom));
            end
        endcase
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (request_queue.size() > 0 &&
                (($urandom_range(0, 99) >= 12) ||
                 (cycle_count >= quiet_from && cycle_count < quiet_to))) begin
                i_in_data  <= request_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) bridge_predict(i_in_data);
    end

    // Receiver stall: random, with one long hold-off and none in the quiet window
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (hold_off > 0) begin
            hold_off    <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else if (cycle_count == 200) begin
            hold_off    <= 60;
            i_out_stall <= 1'b1;
        end else if (cycle_count >= quiet_from && cycle_count < quiet_to) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 12);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result t=%0d v=%02h l=%0d",
                    o_out_data.target, o_out_data.value, o_out_data.last));
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.target != want.target)
                    report($sformatf("target %0d, want %0d", o_out_data.target, want.target));
                if (o_out_data.value != want.value)
                    report($sformatf("value %02h, want %02h", o_out_data.value, want.value));
                if (o_out_data.last != want.last)
                    report($sformatf("last %0d, want %0d", o_out_data.last, want.last));
            end
        end
    end

    // Watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        br_phase = PH_IDLE; br_cmd = '0; br_count = '0; br_addr = '0; br_crc_left = '0;
        br_play_left = '0; br_playing = 1'b0; br_crc = '0; br_wait_reply = 1'b0; br_fill = '0;
        quiet_from = 60;
        quiet_to = 160;

        // Directed: ignored items, bad command, hash as data, zero lengths, id
        send(2'd3, 8'hff);
        send(K_SPI, 8'h00);
        send(K_TICK, 8'h00);
        cmd(8'h7f);
        cmd("5"); send(K_UART, 8'h00); send(K_UART, 8'h00); send(K_UART, 8'h00);
        send(K_TICK, 8'h00); replies(4);
        cmd("0"); send(K_UART, 8'hff); replies(3); send(K_SPI, 8'hff); send(K_SPI, 8'h00);
        cmd("3"); replies(1); send(K_UART, C_HASH); replies(1); send(K_UART, 8'h00);
        replies(1); send(K_UART, 8'hff); replies(1); send(K_UART, 8'h00);
        replies(PAGE_BYTES);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() < 295) random_command();
        // stop playback mid-way
        cmd("4"); send(K_UART, 8'h00); send(K_UART, 8'h00); send(K_UART, 8'h01);
        send(K_UART, 8'h00); send(K_UART, 8'h00); send(K_UART, 8'h09); replies(4);
        send(K_TICK, 8'h00); replies(1); cmd(8'h00);

        guard = 0;
        while ((request_queue.size() > 0 || i_in_valid) && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        stim_done = 1;
        guard = 0;
        while (expected_results.size() > 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0 && guard < 20000) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
